### hw/rtl/vxatlas_pkg.sv
package vxatlas_pkg;

    localparam int ROWLEN_W = 11;
    localparam int AREA_W   = 21;
    localparam int Q_W      = 32;
    localparam int MM_W     = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_LENGTH = 3'd0,
        REG_SLICE_AREA = 3'd1,
        REG_CENTER_X   = 3'd2,
        REG_CENTER_Y   = 3'd3,
        REG_Z_BASE     = 3'd4,
        REG_MM_X       = 3'd5,
        REG_MM_Y       = 3'd6,
        REG_MM_Z       = 3'd7
    } cfg_reg_t;

    localparam logic [MM_W-1:0] MM_RESET = 24'd65536;

endpackage

### hw/rtl/voxel_index_to_atlas_coord.sv
// Channel | Direction | Ports                                   | Handshake
// s_      | in        | s_voxel_index                           | s_valid / s_ready
// m_      | out       | m_col m_row m_slice m_atlas_x/y/z m_saturated | m_valid / m_ready
// cfg     | in        | cfg_index cfg_wr_data                   | cfg_wr_en, no wait
//
// One word enters per cycle while the output word is taken or the output is empty.
// The pipe holds two restoring dividers, one quotient bit per stage: INDEX_BITS
// stages for slice, 21 stages for row and col; each divider has a load stage ahead
// of it, then a multiply stage and a clip stage follow.
// aresetn (synchronous) clears all valid bits; config registers reset to their defaults.
// A stall at m_ halts the whole pipe; s_ready drops only while the output word waits.
module voxel_index_to_atlas_coord #(
    parameter int INDEX_BITS = 30,
    parameter int DIM_BITS   = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [vxatlas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vxatlas_pkg::Q_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [INDEX_BITS-1:0]               s_voxel_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [DIM_BITS-1:0]                 m_col,
    output logic [DIM_BITS-1:0]                 m_row,
    output logic [INDEX_BITS-1:0]               m_slice,
    output logic signed [vxatlas_pkg::Q_W-1:0]  m_atlas_x,
    output logic signed [vxatlas_pkg::Q_W-1:0]  m_atlas_y,
    output logic signed [vxatlas_pkg::Q_W-1:0]  m_atlas_z,
    output logic                                m_saturated
);

    localparam int RL_W  = vxatlas_pkg::ROWLEN_W;
    localparam int AR_W  = vxatlas_pkg::AREA_W;
    localparam int QW    = vxatlas_pkg::Q_W;
    localparam int MMW   = vxatlas_pkg::MM_W;
    localparam int MUL_B = (INDEX_BITS > AR_W + 1) ? INDEX_BITS : AR_W + 1;
    localparam int EXT_W = MMW + MUL_B + 2;
    localparam int DW    = DIM_BITS + RL_W;
    localparam int XP_W  = MMW + RL_W + 1;
    localparam int YP_W  = MMW + AR_W + 1;
    localparam int ZP_W  = MMW + INDEX_BITS;
    localparam logic signed [EXT_W-1:0] Q_MAX_E = EXT_W'(2147483647);
    localparam logic signed [EXT_W-1:0] Q_MIN_E = -EXT_W'(64'sd2147483648);
    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    // configuration
    logic [RL_W-1:0]       row_length_reg;
    logic [AR_W-1:0]       slice_area_reg;
    logic signed [QW-1:0]  center_x_reg, center_y_reg, z_base_reg;
    logic [MMW-1:0]        mm_x_reg, mm_y_reg, mm_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= RL_W'(1);
            slice_area_reg <= AR_W'(1);
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            z_base_reg     <= '0;
            mm_x_reg       <= vxatlas_pkg::MM_RESET;
            mm_y_reg       <= vxatlas_pkg::MM_RESET;
            mm_z_reg       <= vxatlas_pkg::MM_RESET;
        end else if (cfg_wr_en) begin
            unique case (vxatlas_pkg::cfg_reg_t'(cfg_index))
                vxatlas_pkg::REG_ROW_LENGTH: begin
                    // zero divisor acts as one
                    row_length_reg <= (cfg_wr_data[RL_W-1:0] == '0) ? RL_W'(1)
                                                                    : cfg_wr_data[RL_W-1:0];
                end
                vxatlas_pkg::REG_SLICE_AREA: begin
                    slice_area_reg <= (cfg_wr_data[AR_W-1:0] == '0) ? AR_W'(1)
                                                                    : cfg_wr_data[AR_W-1:0];
                end
                vxatlas_pkg::REG_CENTER_X: center_x_reg <= cfg_wr_data;
                vxatlas_pkg::REG_CENTER_Y: center_y_reg <= cfg_wr_data;
                vxatlas_pkg::REG_Z_BASE:   z_base_reg   <= cfg_wr_data;
                vxatlas_pkg::REG_MM_X:     mm_x_reg     <= cfg_wr_data[MMW-1:0];
                vxatlas_pkg::REG_MM_Y:     mm_y_reg     <= cfg_wr_data[MMW-1:0];
                vxatlas_pkg::REG_MM_Z:     mm_z_reg     <= cfg_wr_data[MMW-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // divider 1: index / slice_area; num shifts out dividend bits and in quotient bits
    logic                  v1_reg   [0:INDEX_BITS];
    logic [INDEX_BITS-1:0] num1_reg [0:INDEX_BITS];
    logic [AR_W-1:0]       rem1_reg [0:INDEX_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg[0] <= 1'b0;
        end else if (adv) begin
            v1_reg[0] <= s_valid;
        end
        if (adv) begin
            num1_reg[0] <= s_voxel_index;
            rem1_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= INDEX_BITS; k++) begin : g_div1
        logic [AR_W:0] part;
        logic          ge;
        logic [AR_W:0] diff;
        always_comb begin
            part = {rem1_reg[k-1], num1_reg[k-1][INDEX_BITS-1]};
            diff = part - {1'b0, slice_area_reg};
            ge   = part >= {1'b0, slice_area_reg};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v1_reg[k] <= 1'b0;
            end else if (adv) begin
                v1_reg[k] <= v1_reg[k-1];
            end
            if (adv) begin
                num1_reg[k] <= {num1_reg[k-1][INDEX_BITS-2:0], ge};
                rem1_reg[k] <= ge ? diff[AR_W-1:0] : part[AR_W-1:0];
            end
        end
    end

    // divider 2: remainder / row_length
    logic                  v2_reg     [0:AR_W];
    logic [AR_W-1:0]       num2_reg   [0:AR_W];
    logic [RL_W-1:0]       rem2_reg   [0:AR_W];
    logic [INDEX_BITS-1:0] slice2_reg [0:AR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg[0] <= 1'b0;
        end else if (adv) begin
            v2_reg[0] <= v1_reg[INDEX_BITS];
        end
        if (adv) begin
            num2_reg[0]   <= rem1_reg[INDEX_BITS];
            rem2_reg[0]   <= '0;
            slice2_reg[0] <= num1_reg[INDEX_BITS];
        end
    end

    for (genvar k = 1; k <= AR_W; k++) begin : g_div2
        logic [RL_W:0] part;
        logic          ge;
        logic [RL_W:0] diff;
        always_comb begin
            part = {rem2_reg[k-1], num2_reg[k-1][AR_W-1]};
            diff = part - {1'b0, row_length_reg};
            ge   = part >= {1'b0, row_length_reg};
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v2_reg[k] <= 1'b0;
            end else if (adv) begin
                v2_reg[k] <= v2_reg[k-1];
            end
            if (adv) begin
                num2_reg[k]   <= {num2_reg[k-1][AR_W-2:0], ge};
                rem2_reg[k]   <= ge ? diff[RL_W-1:0] : part[RL_W-1:0];
                slice2_reg[k] <= slice2_reg[k-1];
            end
        end
    end

    // multiply stage
    logic                  vm_reg;
    logic [XP_W-1:0]       xp_reg;
    logic [YP_W-1:0]       yp_reg;
    logic [ZP_W-1:0]       zp_reg;
    logic [RL_W-1:0]       colm_reg;
    logic [AR_W-1:0]       rowm_reg;
    logic [INDEX_BITS-1:0] slicem_reg;
    logic [RL_W:0]         col_p1;
    logic [AR_W:0]         row_p1;

    assign col_p1 = {1'b0, rem2_reg[AR_W]} + (RL_W+1)'(1);
    assign row_p1 = {1'b0, num2_reg[AR_W]} + (AR_W+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (adv) begin
            vm_reg <= v2_reg[AR_W];
        end
        if (adv) begin
            xp_reg     <= XP_W'(mm_x_reg) * XP_W'(col_p1);
            yp_reg     <= YP_W'(mm_y_reg) * YP_W'(row_p1);
            zp_reg     <= ZP_W'(mm_z_reg) * ZP_W'(slice2_reg[AR_W]);
            colm_reg   <= rem2_reg[AR_W];
            rowm_reg   <= num2_reg[AR_W];
            slicem_reg <= slice2_reg[AR_W];
        end
    end

    // subtract and clip stage
    logic signed [EXT_W-1:0] x_full, y_full, z_full;
    logic sat_x, sat_y, sat_z;
    logic signed [QW-1:0] x_clip, y_clip, z_clip;
    logic [DW-1:0] col_ext, row_ext;

    always_comb begin
        x_full = EXT_W'(center_x_reg) - $signed({{(EXT_W-XP_W){1'b0}}, xp_reg});
        y_full = $signed({{(EXT_W-YP_W){1'b0}}, yp_reg}) - EXT_W'(center_y_reg);
        z_full = EXT_W'(z_base_reg) - $signed({{(EXT_W-ZP_W){1'b0}}, zp_reg});
        sat_x  = (x_full > Q_MAX_E) || (x_full < Q_MIN_E);
        sat_y  = (y_full > Q_MAX_E) || (y_full < Q_MIN_E);
        sat_z  = (z_full > Q_MAX_E) || (z_full < Q_MIN_E);
        x_clip = (x_full > Q_MAX_E) ? Q_MAX : (x_full < Q_MIN_E) ? Q_MIN : x_full[QW-1:0];
        y_clip = (y_full > Q_MAX_E) ? Q_MAX : (y_full < Q_MIN_E) ? Q_MIN : y_full[QW-1:0];
        z_clip = (z_full > Q_MAX_E) ? Q_MAX : (z_full < Q_MIN_E) ? Q_MIN : z_full[QW-1:0];
        col_ext = DW'(colm_reg);
        row_ext = DW'(rowm_reg);
    end

    logic vo_reg;
    assign m_valid = vo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (adv) begin
            vo_reg <= vm_reg;
        end
        if (adv) begin
            m_col       <= col_ext[DIM_BITS-1:0];
            m_row       <= row_ext[DIM_BITS-1:0];
            m_slice     <= slicem_reg;
            m_atlas_x   <= x_clip;
            m_atlas_y   <= y_clip;
            m_atlas_z   <= z_clip;
            m_saturated <= sat_x || sat_y || sat_z;
        end
    end

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> (m_atlas_x == Q_MAX || m_atlas_x == Q_MIN ||
            m_atlas_y == Q_MAX || m_atlas_y == Q_MIN ||
            m_atlas_z == Q_MAX || m_atlas_z == Q_MIN))
        else $error("saturated flag without a clipped coordinate");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready out of step with output stall");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && vm_reg) |=> m_valid)
        else $error("word lost between multiply and output stage");

endmodule

### tb/sv/atlas_coord_checker.sv
`timescale 1ns / 1ps

module atlas_coord_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [29:0] s_voxel_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [9:0]  m_col,
    input  logic [9:0]  m_row,
    input  logic [29:0] m_slice,
    input  logic [31:0] m_atlas_x,
    input  logic [31:0] m_atlas_y,
    input  logic [31:0] m_atlas_z,
    input  logic        m_saturated,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [9:0]  col;
        logic [9:0]  row;
        logic [29:0] slice;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic        sat;
    } coord_word_t;

    logic [10:0] row_len;
    logic [20:0] area;
    logic [31:0] cx, cy, zb;
    logic [23:0] mmx, mmy, mmz;
    coord_word_t coord_q[$];

    function automatic logic [31:0] clip_q16(input longint v, inout logic sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic coord_word_t map_voxel(input logic [29:0] idx);
        coord_word_t w;
        longint unsigned a, r, sl, rem, rw, cl;
        longint x, y, z;
        logic sat;
        a = (area == 0) ? 1 : area;
        r = (row_len == 0) ? 1 : row_len;
        sl = idx / a;
        rem = idx % a;
        rw = rem / r;
        cl = rem % r;
        sat = 1'b0;
        x = longint'($signed(cx)) - longint'(mmx * (cl + 1));
        y = longint'(mmy * (rw + 1)) - longint'($signed(cy));
        z = longint'($signed(zb)) - longint'(mmz * sl);
        w.col = cl[9:0];
        w.row = rw[9:0];
        w.slice = sl[29:0];
        w.ax = clip_q16(x, sat);
        w.ay = clip_q16(y, sat);
        w.az = clip_q16(z, sat);
        w.sat = sat;
        return w;
    endfunction

    assign pending = coord_q.size();

    always @(posedge aclk) begin
        coord_word_t e;
        if (!aresetn) begin
            row_len <= 1; area <= 1; cx <= 0; cy <= 0; zb <= 0;
            mmx <= vxatlas_pkg::MM_RESET;
            mmy <= vxatlas_pkg::MM_RESET;
            mmz <= vxatlas_pkg::MM_RESET;
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (vxatlas_pkg::cfg_reg_t'(cfg_index))
                    vxatlas_pkg::REG_ROW_LENGTH: row_len <= cfg_wr_data[10:0];
                    vxatlas_pkg::REG_SLICE_AREA: area <= cfg_wr_data[20:0];
                    vxatlas_pkg::REG_CENTER_X:   cx <= cfg_wr_data;
                    vxatlas_pkg::REG_CENTER_Y:   cy <= cfg_wr_data;
                    vxatlas_pkg::REG_Z_BASE:     zb <= cfg_wr_data;
                    vxatlas_pkg::REG_MM_X:       mmx <= cfg_wr_data[23:0];
                    vxatlas_pkg::REG_MM_Y:       mmy <= cfg_wr_data[23:0];
                    vxatlas_pkg::REG_MM_Z:       mmz <= cfg_wr_data[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                coord_q.push_back(map_voxel(s_voxel_index));
            if (m_valid && m_ready) begin
                if (coord_q.size() == 0) begin
                    $display("%0t: unexpected word, got %h", $time,
                             {m_col, m_row, m_slice, m_atlas_x, m_atlas_y, m_atlas_z,
                              m_saturated});
                    fail_count <= fail_count + 1;
                end else begin
                    e = coord_q.pop_front();
                    if (e.col !== m_col || e.row !== m_row || e.slice !== m_slice ||
                        e.ax !== m_atlas_x || e.ay !== m_atlas_y ||
                        e.az !== m_atlas_z || e.sat !== m_saturated) begin
                        $display("%0t: mismatch col/row/slice exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $time, e.col, e.row, e.slice, m_col, m_row, m_slice);
                        $display("%0t: x/y/z/sat exp %h %h %h %b got %h %h %h %b", $time,
                                 e.ax, e.ay, e.az, e.sat,
                                 m_atlas_x, m_atlas_y, m_atlas_z, m_saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int PIPE_LAT = 55;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [29:0] s_voxel_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_col, m_row;
    logic [29:0] m_slice;
    logic [31:0] m_atlas_x, m_atlas_y, m_atlas_z;
    logic        m_saturated;
    int          fail_count, pending;
    logic        hold_off = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    voxel_index_to_atlas_coord dut (.*);

    atlas_coord_checker checker_i (.*);

    // receiver: random stall pattern with clean stretches, plus forced hold-off
    always @(posedge aclk) begin
        int ph;
        ph = int'(($time / 2000) % 3);
        if (hold_off) m_ready <= 1'b0;
        else if (ph == 0) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_reg(input vxatlas_pkg::cfg_reg_t r, input logic [31:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wr_data <= d;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_voxel(input logic [29:0] idx);
        s_valid <= 1'b1;
        s_voxel_index <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    // bursts with random gaps; valid drops only between bursts
    task automatic send_burst(input int n, input logic [29:0] lim);
        for (int i = 0; i < n; i++)
            send_voxel(($urandom_range(0, 7) == 0) ? 30'($urandom())
                                                   : 30'($urandom_range(0, lim)));
        s_valid <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge aclk);
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_LAT + 5) @(posedge aclk);
    endtask

    task automatic config_all(input logic [31:0] rl, input logic [31:0] ar,
                              input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] mx,
                              input logic [31:0] my, input logic [31:0] mz);
        write_reg(vxatlas_pkg::REG_ROW_LENGTH, rl);
        write_reg(vxatlas_pkg::REG_SLICE_AREA, ar);
        write_reg(vxatlas_pkg::REG_CENTER_X, x);
        write_reg(vxatlas_pkg::REG_CENTER_Y, y);
        write_reg(vxatlas_pkg::REG_Z_BASE, z);
        write_reg(vxatlas_pkg::REG_MM_X, mx);
        write_reg(vxatlas_pkg::REG_MM_Y, my);
        write_reg(vxatlas_pkg::REG_MM_Z, mz);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset settings: extremes of the index
        send_voxel('0);
        send_voxel('1);
        send_voxel(30'h2aaa_aaaa);
        send_voxel(30'h1555_5555);
        drain();
        // zero divisors act as one
        config_all(0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   24'hff_ffff, 24'hff_ffff, 24'hff_ffff);
        send_voxel('0);
        send_voxel(1);
        send_voxel('1);
        drain();
        // oversized rows and columns, saturation both ways
        config_all(1024, 32'hfff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                   24'hff_ffff, 0, 1);
        send_voxel(1023);
        send_voxel(1024);
        send_voxel(2097150);
        send_voxel(2097151);
        send_voxel('1);
        drain();
        config_all(2047, 1048576, 0, 0, 0, 0, 24'hff_ffff, 0);
        send_voxel(2046);
        send_voxel(1048575);
        send_voxel(1048576);
        send_voxel('1);
        drain();
        // long hold-off: pipe fills, s_ready must drop
        config_all(64, 4096, 32'h0050_0000, 32'h0040_0000, 32'h0080_0000,
                   24'h01_0000, 24'h01_8000, 24'h02_0000);
        hold_off <= 1'b1;
        fork
            send_burst(120, 30'hf_ffff);
            begin repeat (300) @(posedge aclk); hold_off <= 1'b0; end
        join
        drain();
        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            logic [31:0] rl, ar;
            rl = (ph == 0) ? 1 : (ph == 1) ? 1024 : $urandom_range(1, 1024);
            ar = (ph == 0) ? 1 : (ph == 1) ? 1048576 : rl * $urandom_range(1, 1024);
            if (ar > 1048576) ar = 1048576;
            if (ph == 7) ar = $urandom();
            config_all(rl, ar, $urandom(), $urandom(), $urandom(),
                       $urandom_range(0, 24'hff_ffff), $urandom_range(0, 24'h0f_ffff),
                       $urandom_range(0, 24'h00_ffff));
            for (int n = 0; n < 100; ) begin
                int b;
                b = $urandom_range(1, 20);
                send_burst(b, (ph < 4) ? 30'h3fff_ffff : 30'(ar * 8));
                n += b;
            end
            drain();
        end
        if (fail_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
